@@ sv/assert_macros.svh @@
// Assertion macros for the heat stencil RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define HDS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define HDS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HDS_ASSERT(label, clk, rst, prop, msg)
`define HDS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

@@ sv/hds_pkg.sv @@
// Shared types and constants for the heat diffusion stencil sweep.
// Used by hds_ctrl, hds_datapath and the top level; no dependencies.
package hds_pkg;

   localparam int INT_BITS   = 7;
   localparam int GRID_REG_W = 6;
   localparam int COEF_W     = 15;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;

   localparam logic [GRID_REG_W-1:0] MIN_GRID        = 6'd4;
   localparam logic [GRID_REG_W-1:0] GRID_RESET      = 6'd32;
   localparam logic [COEF_W-1:0]     COEF_RESET      = 15'd15729;

   localparam logic [CSR_IDX_W-1:0]  CSR_SIDE_LEN    = 2'd0;
   localparam logic [CSR_IDX_W-1:0]  CSR_DIFF_COEF   = 2'd1;

   typedef struct packed {
      logic capture;
      logic rd_en;
      logic wr_en;
      logic lap_en;
      logic mul_en;
      logic fin_en;
      logic flush;
      logic use_up;
      logic use_left;
      logic use_right;
      logic use_down;
      logic last;
   } hds_cmd_type;

endpackage

@@ sv/heat_diffusion_stencil_sweep_top.sv @@
// Heat stencil top: one Jacobi five-point sweep over a raster stream of grid cells.
// An item with no result (top row) takes the row-buffer read and laplacian steps; an item that
// yields a result also takes the multiply and the floor-and-saturate step, which waits out
// rsp_stall. The bottom-right cell then flushes the bottom row, n more results, each the same way.
// A new cell waits on req_stall until the last is done. Each row memory has two registered reads.
// Row buffers start cleared through per-entry valid bits, so no clearing pass follows reset.
// Depends on hds_pkg, hds_ctrl and hds_datapath.
module heat_diffusion_stencil_sweep_top #(
   parameter int GRID_SIZE = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [hds_pkg::INT_BITS+FRAC_BITS-1:0]   req_cell_value,
   input  logic                                     req_first_cell,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [hds_pkg::INT_BITS+FRAC_BITS-1:0]   rsp_new_value,
   output logic                                     rsp_last_of_sweep,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [hds_pkg::CSR_IDX_W-1:0]            csr_index,
   input  logic [hds_pkg::CSR_DATA_W-1:0]           csr_wdata
);
   import hds_pkg::*;

   localparam int IDX_W = $clog2(GRID_SIZE);

   logic [GRID_REG_W-1:0] side_len_ff;
   logic [COEF_W-1:0]     coef_ff;
   hds_cmd_type           cmd;
   logic [IDX_W-1:0]      addr_center, addr_left, addr_right;
   logic                  out_free;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_len_ff <= GRID_RESET;
         coef_ff     <= COEF_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_SIDE_LEN) begin
            side_len_ff <= csr_wdata[GRID_REG_W-1:0];
         end
         if (csr_index == CSR_DIFF_COEF) begin
            coef_ff <= csr_wdata[COEF_W-1:0];
         end
      end
   end

   hds_ctrl #(
      .GRID_SIZE (GRID_SIZE)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_first_cell (req_first_cell),
      .req_stall      (req_stall),
      .side_len       (side_len_ff),
      .out_free       (out_free),
      .cmd            (cmd),
      .addr_center    (addr_center),
      .addr_left      (addr_left),
      .addr_right     (addr_right)
   );

   hds_datapath #(
      .GRID_SIZE (GRID_SIZE),
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .addr_center       (addr_center),
      .addr_left         (addr_left),
      .addr_right        (addr_right),
      .coef              (coef_ff),
      .cell_value        (req_cell_value),
      .rsp_stall         (rsp_stall),
      .out_free          (out_free),
      .rsp_valid         (rsp_valid),
      .rsp_new_value     (rsp_new_value),
      .rsp_last_of_sweep (rsp_last_of_sweep)
   );

endmodule

@@ sv/hds_ctrl.sv @@
// Sequencer for the heat stencil: grid position, per-item steps and the bottom-row flush.
// Depends on hds_pkg and assert_macros.svh; drives hds_datapath through hds_cmd_type.
`include "assert_macros.svh"
module hds_ctrl #(
   parameter int GRID_SIZE = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_first_cell,
   output logic                            req_stall,
   input  logic [hds_pkg::GRID_REG_W-1:0]  side_len,
   input  logic                            out_free,
   output hds_pkg::hds_cmd_type            cmd,
   output logic [$clog2(GRID_SIZE)-1:0]    addr_center,
   output logic [$clog2(GRID_SIZE)-1:0]    addr_left,
   output logic [$clog2(GRID_SIZE)-1:0]    addr_right
);
   import hds_pkg::*;

   localparam int IDX_W = $clog2(GRID_SIZE);
   localparam int N_W   = $clog2(GRID_SIZE + 1);
   localparam logic [GRID_REG_W-1:0] MAX_N = GRID_REG_W'(GRID_SIZE);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_READ = 5'b00010,
      S_LAP  = 5'b00100,
      S_MUL  = 5'b01000,
      S_FIN  = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] row_ff, row_in, col_ff, col_in;
   logic [IDX_W-1:0] cur_row_ff, cur_row_in, cur_col_ff, cur_col_in;
   logic [IDX_W-1:0] flush_col_ff, flush_col_in;
   logic [N_W-1:0]   n_ff, n_in;
   logic             flush_ff, flush_in, corner_ff, corner_in;

   logic [GRID_REG_W-1:0] n_sat;
   logic [N_W-1:0]        n_live;
   logic [IDX_W-1:0]      live_m1, n_m1, pos_r, pos_c, pos;
   logic                  accept, restart;

   always_comb begin
      if (side_len < MIN_GRID) begin
         n_sat = MIN_GRID;
      end else if (side_len > MAX_N) begin
         n_sat = MAX_N;
      end else begin
         n_sat = side_len;
      end
   end

   assign n_live  = N_W'(n_sat);
   assign live_m1 = IDX_W'(n_live - N_W'(1));
   assign n_m1    = IDX_W'(n_ff - N_W'(1));
   assign restart = req_first_cell || (N_W'(row_ff) >= n_live) || (N_W'(col_ff) >= n_live);
   assign pos_r   = restart ? '0 : row_ff;
   assign pos_c   = restart ? '0 : col_ff;
   assign req_stall = (state_ff != S_IDLE);
   assign accept  = req_valid && !req_stall;

   assign pos         = flush_ff ? flush_col_ff : cur_col_ff;
   assign addr_center = pos;
   assign addr_left   = (pos == '0) ? pos : pos - IDX_W'(1);
   assign addr_right  = (pos == n_m1) ? pos : pos + IDX_W'(1);

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      flush_col_in = flush_col_ff;
      n_in         = n_ff;
      flush_in     = flush_ff;
      corner_in    = corner_ff;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               cur_row_in  = pos_r;
               cur_col_in  = pos_c;
               n_in        = n_live;
               corner_in   = (pos_r == live_m1) && (pos_c == live_m1);
               if (pos_c == live_m1) begin
                  col_in = '0;
                  row_in = (pos_r == live_m1) ? '0 : pos_r + IDX_W'(1);
               end else begin
                  col_in = pos_c + IDX_W'(1);
                  row_in = pos_r;
               end
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = S_LAP;
         end
         S_LAP: begin
            cmd.lap_en    = 1'b1;
            cmd.wr_en     = !flush_ff;
            cmd.flush     = flush_ff;
            cmd.use_up    = flush_ff || (cur_row_ff > IDX_W'(1));
            cmd.use_left  = (pos != '0);
            cmd.use_right = (pos != n_m1);
            cmd.use_down  = !flush_ff;
            if (flush_ff || (cur_row_ff != '0)) begin
               state_in = S_MUL;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               cmd.fin_en = 1'b1;
               cmd.last   = flush_ff && (flush_col_ff == n_m1);
               if (flush_ff) begin
                  if (flush_col_ff == n_m1) begin
                     flush_in = 1'b0;
                     state_in = S_IDLE;
                  end else begin
                     flush_col_in = flush_col_ff + IDX_W'(1);
                     state_in     = S_READ;
                  end
               end else if (corner_ff) begin
                  flush_in     = 1'b1;
                  flush_col_in = '0;
                  state_in     = S_READ;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         flush_col_ff <= '0;
         n_ff         <= N_W'(GRID_SIZE);
         flush_ff     <= 1'b0;
         corner_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         flush_col_ff <= flush_col_in;
         n_ff         <= n_in;
         flush_ff     <= flush_in;
         corner_ff    <= corner_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_row_ff <= cur_row_in;
      cur_col_ff <= cur_col_in;
   end

   `HDS_ASSERT(a_fin_needs_room, clock, reset, cmd.fin_en |-> out_free, "rsp register busy")
   `HDS_ASSERT(a_flush_in_grid, clock, reset, flush_ff |-> (N_W'(flush_col_ff) < n_ff), "flush col")
   `HDS_ASSERT(a_accept_reads, clock, reset, accept |=> (state_ff == S_READ), "no row read")
   `HDS_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> ((state_ff == S_IDLE) && !flush_ff), "busy")

endmodule

@@ sv/hds_datapath.sv @@
// Row buffers, five-point update arithmetic and result register for the heat stencil.
// Depends on hds_pkg; sequenced by hds_ctrl.
module hds_datapath #(
   parameter int GRID_SIZE = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  hds_pkg::hds_cmd_type                     cmd,
   input  logic [$clog2(GRID_SIZE)-1:0]             addr_center,
   input  logic [$clog2(GRID_SIZE)-1:0]             addr_left,
   input  logic [$clog2(GRID_SIZE)-1:0]             addr_right,
   input  logic [hds_pkg::COEF_W-1:0]               coef,
   input  logic [hds_pkg::INT_BITS+FRAC_BITS-1:0]   cell_value,
   input  logic                                     rsp_stall,
   output logic                                     out_free,
   output logic                                     rsp_valid,
   output logic [hds_pkg::INT_BITS+FRAC_BITS-1:0]   rsp_new_value,
   output logic                                     rsp_last_of_sweep
);
   import hds_pkg::*;

   localparam int VB     = INT_BITS + FRAC_BITS;
   localparam int SUM_W  = VB + 2;
   localparam int LAP_W  = VB + 3;
   localparam int PROD_W = LAP_W + COEF_W + 1;
   localparam int DEL_W  = PROD_W - FRAC_BITS;
   localparam int RES_W  = ((DEL_W > VB + 1) ? DEL_W : VB + 1) + 1;

   logic [VB-1:0] above_mem  [GRID_SIZE];
   logic [VB-1:0] middle_mem [GRID_SIZE];
   logic [GRID_SIZE-1:0] above_vld_ff, middle_vld_ff;

   logic [VB-1:0] up_q, left_q, ce_q, rt_q;
   logic          up_vq, left_vq, ce_vq, rt_vq;
   logic [VB-1:0] up_val, left_val, ce_val, rt_val, left_src;
   logic [VB-1:0] cell_ff, center_ff, prev_ff;
   logic [SUM_W-1:0] sum;
   logic signed [LAP_W-1:0]  lap_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [RES_W-1:0]  delta_x, center_x, res;
   logic [VB-1:0] sat_val;
   logic          rsp_valid_ff;
   logic [VB-1:0] rsp_value_ff;
   logic          rsp_last_ff;

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         up_q   <= above_mem[addr_center];
         left_q <= above_mem[addr_left];
         ce_q   <= middle_mem[addr_center];
         rt_q   <= middle_mem[addr_right];
      end
      if (cmd.wr_en) begin
         above_mem[addr_center]  <= ce_val;
         middle_mem[addr_center] <= cell_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         up_vq   <= above_vld_ff[addr_center];
         left_vq <= above_vld_ff[addr_left];
         ce_vq   <= middle_vld_ff[addr_center];
         rt_vq   <= middle_vld_ff[addr_right];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         above_vld_ff  <= '0;
         middle_vld_ff <= '0;
      end else if (cmd.wr_en) begin
         above_vld_ff[addr_center]  <= 1'b1;
         middle_vld_ff[addr_center] <= 1'b1;
      end
   end

   assign up_val   = up_vq   ? up_q   : '0;
   assign left_val = left_vq ? left_q : '0;
   assign ce_val   = ce_vq   ? ce_q   : '0;
   assign rt_val   = rt_vq   ? rt_q   : '0;
   assign left_src = cmd.flush ? prev_ff : left_val;

   assign sum = (cmd.use_up    ? SUM_W'(up_val)   : '0)
              + (cmd.use_left  ? SUM_W'(left_src) : '0)
              + (cmd.use_right ? SUM_W'(rt_val)   : '0)
              + (cmd.use_down  ? SUM_W'(cell_ff)  : '0);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cell_ff <= cell_value;
      end
      if (cmd.lap_en) begin
         lap_ff    <= $signed({1'b0, sum}) - $signed({1'b0, ce_val, 2'b00});
         center_ff <= ce_val;
         prev_ff   <= ce_val;
      end
      if (cmd.mul_en) begin
         prod_ff <= PROD_W'(lap_ff) * $signed({1'b0, coef});
      end
   end

   assign delta_x  = RES_W'($signed(prod_ff[PROD_W-1:FRAC_BITS]));
   assign center_x = RES_W'({1'b0, center_ff});
   assign res      = center_x + delta_x;

   always_comb begin
      if (res[RES_W-1]) begin
         sat_val = '0;
      end else if (|res[RES_W-2:VB]) begin
         sat_val = '1;
      end else begin
         sat_val = res[VB-1:0];
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.fin_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fin_en) begin
         rsp_value_ff <= sat_val;
         rsp_last_ff  <= cmd.last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_new_value     = rsp_value_ff;
   assign rsp_last_of_sweep = rsp_last_ff;

endmodule

@@ tb/heat_diffusion_stencil_sweep_top_tb.sv @@
// Testbench for heat_diffusion_stencil_sweep_top: streams grid cells through the stencil, predicts
// every swept cell in place and checks each rsp transaction against it, over several grid settings.
// Depends on hds_pkg and the top level RTL only.
`timescale 1ns / 1ps

module heat_diffusion_stencil_sweep_top_tb;
   import hds_pkg::*;

   localparam int GRID_SIZE     = 32;
   localparam int FRAC_BITS     = 16;
   localparam int VW            = INT_BITS + FRAC_BITS;
   localparam int RANDOM_CELLS  = 400;
   localparam int SETTLE_CYCLES = 32;
   localparam int DRAIN_BOUND   = 50000;
   localparam int HOLD_CYCLES   = 400;

   localparam logic [VW-1:0] MAX_CELL   = '1;
   localparam longint        CELL_CEIL  = (64'd1 << VW) - 1;

   typedef struct packed {
      logic [VW-1:0] value;
      logic          first;
      logic          typed;
      logic [VW-1:0] known;
   } script_row_type;

   typedef struct {
      logic [VW-1:0] value;
      logic          last;
   } swept_cell_type;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   // n = 4, k = 0.25: zero rows, then a full-scale row under a zero row, then edge restarts
   localparam script_row_type SCRIPT[24] = '{
      '{23'd0, 1'b1, 1'b0, 23'd0},
      '{23'd0, 1'b0, 1'b0, 23'd0},
      '{23'd0, 1'b0, 1'b0, 23'd0},
      '{23'd0, 1'b0, 1'b0, 23'd0},
      '{23'd0, 1'b0, 1'b1, 23'd0},
      '{23'd0, 1'b0, 1'b1, 23'd0},
      '{23'd0, 1'b0, 1'b1, 23'd0},
      '{23'd0, 1'b0, 1'b1, 23'd0},
      '{MAX_CELL, 1'b0, 1'b1, 23'd2097151},
      '{MAX_CELL, 1'b0, 1'b1, 23'd2097151},
      '{MAX_CELL, 1'b0, 1'b1, 23'd2097151},
      '{MAX_CELL, 1'b0, 1'b1, 23'd2097151},
      '{23'd0, 1'b0, 1'b0, 23'd0},
      '{23'd0, 1'b0, 1'b0, 23'd0},
      '{23'd0, 1'b0, 1'b0, 23'd0},
      '{23'd0, 1'b0, 1'b0, 23'd0},
      '{MAX_CELL, 1'b1, 1'b0, 23'd0},
      '{23'h2AAAAA, 1'b0, 1'b0, 23'd0},
      '{23'h555555, 1'b0, 1'b0, 23'd0},
      '{23'd0, 1'b0, 1'b0, 23'd0},
      '{23'h555555, 1'b1, 1'b0, 23'd0},
      '{23'h2AAAAA, 1'b0, 1'b0, 23'd0},
      '{MAX_CELL, 1'b0, 1'b0, 23'd0},
      '{23'h123456, 1'b0, 1'b0, 23'd0}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [VW-1:0]         req_cell_value = '0;
   logic                  req_first_cell = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [VW-1:0]         rsp_new_value;
   logic                  rsp_last_of_sweep;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic [GRID_REG_W-1:0] grid_cfg;
   logic [COEF_W-1:0]     coef_cfg;
   logic [VW-1:0]         row_above[GRID_SIZE];
   logic [VW-1:0]         row_mid[GRID_SIZE];
   int                    row_pos;
   int                    col_pos;
   swept_cell_type        swept_cells[$];

   int             cells_sent = 0;
   int             results_seen = 0;
   int             mismatches = 0;
   int             configs_run = 0;
   int             burst_left = 0;
   logic           streaming = 1'b0;
   logic           hold_done = 1'b0;
   int             hold_left = 0;
   int             pattern_left = 0;
   stall_mode_type pattern_mode = STALL_NONE;

   heat_diffusion_stencil_sweep_top #(
      .GRID_SIZE(GRID_SIZE),
      .FRAC_BITS(FRAC_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cell_value(req_cell_value),
      .req_first_cell(req_first_cell),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_new_value(rsp_new_value),
      .rsp_last_of_sweep(rsp_last_of_sweep),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic int grid_in_use();
      if (grid_cfg < MIN_GRID) return int'(MIN_GRID);
      if (int'(grid_cfg) > GRID_SIZE) return GRID_SIZE;
      return int'(grid_cfg);
   endfunction

   function automatic logic [VW-1:0] relax_cell(logic [VW-1:0] center, longint total);
      longint lap;
      longint delta;
      longint res;
      lap = total - 4 * longint'(center);
      delta = (lap * longint'(coef_cfg)) >>> FRAC_BITS;
      res = longint'(center) + delta;
      if (res < 0) res = 0;
      if (res > CELL_CEIL) res = CELL_CEIL;
      return res[VW-1:0];
   endfunction

   function automatic void stencil_step(logic [VW-1:0] v, logic first);
      int             n;
      int             r;
      int             c;
      longint         total;
      swept_cell_type swept;
      n = grid_in_use();
      r = row_pos;
      c = col_pos;
      if (first || r >= n || c >= n) begin
         r = 0;
         c = 0;
      end
      if (r > 0) begin
         total = longint'(v);
         if (r > 1) total += longint'(row_above[c]);
         if (c > 0) total += longint'(row_above[c-1]);
         if (c < n - 1) total += longint'(row_mid[c+1]);
         swept.value = relax_cell(row_mid[c], total);
         swept.last = 1'b0;
         swept_cells.push_back(swept);
      end
      row_above[c] = row_mid[c];
      row_mid[c] = v;
      if (r == n - 1 && c == n - 1) begin
         for (int j = 0; j < n; j++) begin
            total = longint'(row_above[j]);
            if (j > 0) total += longint'(row_mid[j-1]);
            if (j < n - 1) total += longint'(row_mid[j+1]);
            swept.value = relax_cell(row_mid[j], total);
            swept.last = (j == n - 1);
            swept_cells.push_back(swept);
         end
      end
      if (c + 1 >= n) begin
         col_pos = 0;
         row_pos = (r + 1 >= n) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
         row_pos = r;
      end
   endfunction

   function automatic logic [VW-1:0] random_cell();
      logic [31:0] raw;
      raw = $urandom();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return MAX_CELL;
         2: return {{(VW-8){1'b0}}, raw[7:0]};
         default: return raw[VW-1:0];
      endcase
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_SIDE_LEN) grid_cfg = data[GRID_REG_W-1:0];
      else if (idx == CSR_DIFF_COEF) coef_cfg = data[COEF_W-1:0];
   endtask

   task automatic configure(logic [GRID_REG_W-1:0] grid, logic [COEF_W-1:0] coef);
      logic [CSR_DATA_W-GRID_REG_W-1:0] pad;
      pad = (CSR_DATA_W-GRID_REG_W)'($urandom());
      write_reg(CSR_SIDE_LEN, {pad, grid});
      write_reg(CSR_DIFF_COEF, coef);
      csr_valid <= 1'b0;
      configs_run++;
   endtask

   task automatic offer_cell(logic [VW-1:0] v, logic first);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 16);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_cell_value <= v;
      req_first_cell <= first;
      do @(posedge clock); while (req_stall);
      stencil_step(v, first);
      cells_sent++;
   endtask

   task automatic settle_block();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (swept_cells.size() != 0 && waited < DRAIN_BOUND) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      swept_cell_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen <= results_seen + 1;
         if (swept_cells.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected transaction: expected none, actual new_value %0d last %0b",
                     $time, rsp_new_value, rsp_last_of_sweep);
         end else begin
            want = swept_cells.pop_front();
            if (rsp_new_value !== want.value) begin
               mismatches++;
               $display("%0t: new_value mismatch: expected %0d, actual %0d",
                        $time, want.value, rsp_new_value);
            end
            if (rsp_last_of_sweep !== want.last) begin
               mismatches++;
               $display("%0t: last_of_sweep mismatch: expected %0b, actual %0b",
                        $time, want.last, rsp_last_of_sweep);
            end
         end
      end
   end

   // hold off once for a long stretch mid-stream, otherwise follow a shifting stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && streaming && results_seen >= 30) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         if (pattern_left == 0) begin
            pattern_mode = stall_mode_type'($urandom_range(0, 3));
            pattern_left = $urandom_range(20, 80);
         end
         pattern_left--;
         case (pattern_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= (pattern_left % 3 == 0);
         endcase
      end
   end

   initial begin
      logic [GRID_REG_W-1:0] grid;
      logic [COEF_W-1:0]     coef;
      int                    n;
      int                    span;
      logic                  first;
      foreach (row_above[i]) begin
         row_above[i] = '0;
         row_mid[i] = '0;
      end
      row_pos = 0;
      col_pos = 0;
      grid_cfg = GRID_RESET;
      coef_cfg = COEF_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      configure(6'd4, 15'd16384);
      for (int i = 0; i < $size(SCRIPT); i++) begin
         offer_cell(SCRIPT[i].value, SCRIPT[i].first);
         if (SCRIPT[i].typed) swept_cells[swept_cells.size()-1].value = SCRIPT[i].known;
      end

      while (cells_sent < $size(SCRIPT) + RANDOM_CELLS) begin
         settle_block();
         case (configs_run)
            1: begin
               grid = 6'd63;
               coef = 15'h7FFF;
            end
            2: begin
               grid = 6'd0;
               coef = 15'd0;
            end
            3: begin
               grid = 6'd32;
               coef = 15'd16384;
            end
            default: begin
               case ($urandom_range(0, 11))
                  0: grid = GRID_REG_W'($urandom_range(0, 3));
                  1: grid = GRID_REG_W'($urandom_range(9, 16));
                  2: grid = GRID_REG_W'($urandom_range(33, 63));
                  default: grid = GRID_REG_W'($urandom_range(4, 8));
               endcase
               case ($urandom_range(0, 5))
                  0: coef = 15'd0;
                  1: coef = 15'd16384;
                  2: coef = 15'h7FFF;
                  3: coef = COEF_RESET;
                  default: coef = COEF_W'($urandom_range(0, 32767));
               endcase
            end
         endcase
         configure(grid, coef);
         n = grid_in_use();
         if (n <= 8) span = n * n * $urandom_range(1, 3);
         else span = n * $urandom_range(2, 4) + $urandom_range(0, n - 1);
         streaming <= 1'b1;
         for (int i = 0; i < span && cells_sent < $size(SCRIPT) + RANDOM_CELLS; i++) begin
            if (i % (n * n) == 0) first = ($urandom_range(0, 7) != 0);
            else first = ($urandom_range(0, 49) == 0);
            offer_cell(random_cell(), first);
         end
         streaming <= 1'b0;
      end

      settle_block();
      if (swept_cells.size() != 0) begin
         mismatches++;
         $display("%0t: %0d expected cells never arrived", $time, swept_cells.size());
      end
      $display("Swept %0d cells under %0d grid/coefficient settings; %0d results checked.",
               cells_sent, configs_run, results_seen);
      $display("Grids 4 to 32 with clamped writes, coefficients 0 to 32767, %0d mismatches.",
               mismatches);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+sv
sv/hds_pkg.sv
sv/hds_ctrl.sv
sv/hds_datapath.sv
sv/heat_diffusion_stencil_sweep_top.sv
tb/heat_diffusion_stencil_sweep_top_tb.sv
